FILE: src/prd_pkg.sv
`default_nettype none

package prd_pkg;

   localparam int DATA_W      = 8;
   localparam int FID_W       = 4;
   localparam int POS_W       = 5;
   localparam int VALUE_W     = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int RSP_TDATA_W = 48;

   // record layout pieces that do not move with the text lengths
   localparam int VALUE_BYTES     = 4;
   localparam int IN_TAIL_FIELDS  = 12;
   localparam int OUT_TAIL_FIELDS = 11;
   localparam int MAX_RESULTS     = 21;

   localparam logic [DATA_W-1:0] VOLT_LIMIT      = 8'd120;
   localparam logic [DATA_W-1:0] CHAR_DASH       = 8'h2D;
   localparam logic [DATA_W-1:0] CHAR_DOT        = 8'h2E;
   localparam logic [DATA_W-1:0] CHAR_UNDERSCORE = 8'h5F;

   // register word index (paddr[2])
   localparam logic REG_RECORD_KIND = 1'b0;

   localparam logic KIND_IN  = 1'b0;
   localparam logic KIND_OUT = 1'b1;

   // field ids, input-point layout
   localparam logic [FID_W-1:0] FID_IN_DESC  = 4'd0;
   localparam logic [FID_W-1:0] FID_IN_LABEL = 4'd1;
   localparam logic [FID_W-1:0] FID_IN_VALUE = 4'd2;
   localparam logic [FID_W-1:0] FID_IN_TAIL  = 4'd3;

   // field ids, output-point layout
   localparam logic [FID_W-1:0] FID_OUT_DESC  = 4'd0;
   localparam logic [FID_W-1:0] FID_OUT_LOW   = 4'd1;
   localparam logic [FID_W-1:0] FID_OUT_HIGH  = 4'd2;
   localparam logic [FID_W-1:0] FID_OUT_LABEL = 4'd3;
   localparam logic [FID_W-1:0] FID_OUT_VALUE = 4'd4;
   localparam logic [FID_W-1:0] FID_OUT_TAIL  = 4'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_PUT
   } state_type;

   typedef enum logic [1:0] {
      BK_IN_DESC,
      BK_OUT_DESC,
      BK_IN_LABEL,
      BK_OUT_LABEL
   } burst_type;

   typedef struct packed {
      logic take_byte;
      logic issue_read;
      logic load_item;
   } ctrl_cmd_type;

   typedef struct packed {
      logic start_burst;
      logic last_item;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic [FID_W-1:0]   field_id;
      logic [POS_W-1:0]   byte_pos;
      logic [VALUE_W-1:0] field_value;
      logic               record_end;
      logic               status;
   } result_type;

   function automatic logic [VALUE_W-1:0] volt_clamp(input logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] v;
      v = (b > VOLT_LIMIT) ? '0 : b;
      return {{(VALUE_W-DATA_W){1'b0}}, v};
   endfunction

   function automatic logic [DATA_W-1:0] fold_char(input logic [DATA_W-1:0] c);
      logic [DATA_W-1:0] r;
      r = ((c == CHAR_DASH) || (c == CHAR_DOT)) ? CHAR_UNDERSCORE : c;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: src/prd_ctrl.sv
`default_nettype none

module prd_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   input  prd_pkg::dp_status_type    status,
   output prd_pkg::ctrl_cmd_type     cmd
);

   prd_pkg::state_type state_ff;
   prd_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prd_pkg::ST_IDLE: begin
            if (req_tvalid && status.out_free && status.start_burst) begin
               state_in = prd_pkg::ST_READ;
            end
         end
         prd_pkg::ST_READ: begin
            state_in = prd_pkg::ST_PUT;
         end
         prd_pkg::ST_PUT: begin
            if (status.out_free) begin
               state_in = status.last_item ? prd_pkg::ST_IDLE : prd_pkg::ST_READ;
            end
         end
         default: begin
            state_in = prd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready     = 1'b0;
      cmd            = '0;
      unique case (state_ff)
         prd_pkg::ST_IDLE: begin
            req_tready    = status.out_free;
            cmd.take_byte = req_tvalid && status.out_free;
         end
         prd_pkg::ST_READ: begin
            cmd.issue_read = 1'b1;
         end
         prd_pkg::ST_PUT: begin
            cmd.load_item = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/prd_dpath.sv
`default_nettype none

module prd_dpath #(
   parameter int IN_DESC_LEN  = 21,
   parameter int LABEL_LEN    = 9,
   parameter int OUT_DESC_LEN = 19
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              record_kind,
   input  wire  [prd_pkg::DATA_W-1:0]       req_data,
   input  wire                              req_last,
   input  prd_pkg::ctrl_cmd_type            cmd,
   output prd_pkg::dp_status_type           status,
   input  wire                              rsp_ready,
   output logic                             rsp_valid,
   output prd_pkg::result_type              rsp_item
);

   localparam int IN_LABEL_AT    = IN_DESC_LEN;
   localparam int IN_VALUE_AT    = IN_DESC_LEN + LABEL_LEN;
   localparam int IN_TAIL_AT     = IN_VALUE_AT + prd_pkg::VALUE_BYTES;
   localparam int IN_RECORD_LEN  = IN_TAIL_AT + prd_pkg::IN_TAIL_FIELDS;
   localparam int OUT_LOW_AT     = OUT_DESC_LEN;
   localparam int OUT_HIGH_AT    = OUT_DESC_LEN + 1;
   localparam int OUT_LABEL_AT   = OUT_DESC_LEN + 2;
   localparam int OUT_VALUE_AT   = OUT_LABEL_AT + LABEL_LEN;
   localparam int OUT_TAIL_AT    = OUT_VALUE_AT + prd_pkg::VALUE_BYTES;
   localparam int OUT_RECORD_LEN = OUT_TAIL_AT + prd_pkg::OUT_TAIL_FIELDS;
   localparam int MAX_LEN        = (IN_RECORD_LEN > OUT_RECORD_LEN) ?
                                   IN_RECORD_LEN : OUT_RECORD_LEN;
   localparam int OFF_W          = $clog2(MAX_LEN + 1);
   localparam int TEXT_DEPTH     = (IN_DESC_LEN > OUT_DESC_LEN) ? IN_DESC_LEN : OUT_DESC_LEN;
   localparam int TA_W           = $clog2(TEXT_DEPTH);
   localparam int LA_W           = (LABEL_LEN > 1) ? $clog2(LABEL_LEN) : 1;
   localparam int POS_W          = prd_pkg::POS_W;
   localparam int DATA_W         = prd_pkg::DATA_W;
   localparam int VALUE_W        = prd_pkg::VALUE_W;
   // a burst never carries more results than one byte may cause
   localparam int IN_DESC_LAST   = ((IN_DESC_LEN < prd_pkg::MAX_RESULTS) ?
                                    IN_DESC_LEN : prd_pkg::MAX_RESULTS) - 1;
   localparam int OUT_DESC_LAST  = ((OUT_DESC_LEN + 1 < prd_pkg::MAX_RESULTS) ?
                                    OUT_DESC_LEN + 1 : prd_pkg::MAX_RESULTS) - 1;
   localparam int LABEL_LAST     = LABEL_LEN - 1;
   localparam bit HAS_LOW_ITEM   = OUT_DESC_LEN < prd_pkg::MAX_RESULTS;

   logic [DATA_W-1:0] text_mem  [TEXT_DEPTH];
   logic [DATA_W-1:0] label_mem [LABEL_LEN];

   logic [OFF_W-1:0]    off_ff, off_in;
   logic                done_ff, done_in;
   logic                fan_ff, fan_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   prd_pkg::burst_type  bk_ff, bk_in;
   logic                blank_ff, blank_in;
   logic [DATA_W-1:0]   byte_ff, byte_in;
   logic [POS_W-1:0]    idx_ff, idx_in;
   logic [DATA_W-1:0]   text_rd_ff;
   logic [DATA_W-1:0]   label_rd_ff;
   logic                out_valid_ff, out_valid_in;
   prd_pkg::result_type out_item_ff, out_item_in;

   logic [OFF_W-1:0]    len, label_at, value_at, off_next, lbl_rel;
   logic                nz, done_pre, done_post, in_label, in_value;
   logic                flush_desc, flush_label, blank, start_burst;
   logic [VALUE_W-1:0]  value_new;
   logic                sgl_valid;
   prd_pkg::result_type sgl, burst_item;
   logic [DATA_W-1:0]   lbl_char;
   logic                out_free, last_item;

   // per-byte step of the record decoder
   always_comb begin
      len       = (record_kind == prd_pkg::KIND_OUT) ? OFF_W'(OUT_RECORD_LEN)
                                                     : OFF_W'(IN_RECORD_LEN);
      label_at  = (record_kind == prd_pkg::KIND_OUT) ? OFF_W'(OUT_LABEL_AT)
                                                     : OFF_W'(IN_LABEL_AT);
      value_at  = (record_kind == prd_pkg::KIND_OUT) ? OFF_W'(OUT_VALUE_AT)
                                                     : OFF_W'(IN_VALUE_AT);
      nz        = |req_data;
      done_pre  = done_ff || (off_ff >= len);
      off_next  = off_ff + OFF_W'(1);
      done_post = off_next >= len;
      in_label  = (off_ff >= label_at) && (off_ff < label_at + OFF_W'(LABEL_LEN));
      in_value  = (off_ff >= value_at) && (off_ff < value_at + OFF_W'(prd_pkg::VALUE_BYTES));
      lbl_rel   = off_ff - label_at;
      value_new = in_value ? {req_data, value_ff[VALUE_W-1:DATA_W]} : value_ff;
      flush_desc  = (record_kind == prd_pkg::KIND_OUT) ? (off_ff == OFF_W'(OUT_LOW_AT))
                                                      : (off_ff == OFF_W'(IN_LABEL_AT));
      flush_label = off_ff == value_at;
      blank       = fan_ff && nz;
      start_burst = !done_pre && !req_last && (flush_desc || flush_label);

      sgl       = '0;
      sgl_valid = 1'b0;
      if (!done_pre) begin
         if (req_last && !done_post) begin
            // short buffer: one error item, record discarded downstream
            sgl_valid      = 1'b1;
            sgl.record_end = 1'b1;
            sgl.status     = 1'b1;
         end else if (record_kind == prd_pkg::KIND_IN) begin
            if (off_ff == OFF_W'(IN_VALUE_AT + prd_pkg::VALUE_BYTES - 1)) begin
               sgl_valid       = 1'b1;
               sgl.field_id    = prd_pkg::FID_IN_VALUE;
               sgl.field_value = value_new;
            end else if (off_ff >= OFF_W'(IN_TAIL_AT)) begin
               sgl_valid       = 1'b1;
               sgl.field_id    = prd_pkg::FID_W'(off_ff - OFF_W'(IN_TAIL_AT)
                                                 + OFF_W'(prd_pkg::FID_IN_TAIL));
               sgl.field_value = {{(VALUE_W-DATA_W){1'b0}}, req_data};
            end
         end else begin
            if (off_ff == OFF_W'(OUT_HIGH_AT)) begin
               sgl_valid       = 1'b1;
               sgl.field_id    = prd_pkg::FID_OUT_HIGH;
               sgl.field_value = prd_pkg::volt_clamp(req_data);
            end else if (off_ff == OFF_W'(OUT_VALUE_AT + prd_pkg::VALUE_BYTES - 1)) begin
               sgl_valid       = 1'b1;
               sgl.field_id    = prd_pkg::FID_OUT_VALUE;
               sgl.field_value = value_new;
            end else if (off_ff >= OFF_W'(OUT_TAIL_AT)) begin
               sgl_valid       = 1'b1;
               sgl.field_id    = prd_pkg::FID_W'(off_ff - OFF_W'(OUT_TAIL_AT)
                                                 + OFF_W'(prd_pkg::FID_OUT_TAIL));
               sgl.field_value = {{(VALUE_W-DATA_W){1'b0}}, req_data};
            end
         end
         if (!req_last || done_post) begin
            sgl.record_end = done_post;
         end
      end
   end

   // state update on an accepted byte; end of buffer always restarts
   always_comb begin
      off_in   = off_ff;
      done_in  = done_ff;
      fan_in   = fan_ff;
      value_in = value_ff;
      if (cmd.take_byte) begin
         if (done_pre) begin
            done_in = 1'b1;
         end else begin
            off_in   = off_next;
            done_in  = done_post;
            value_in = value_new;
            if ((off_ff == '0) || (off_ff == label_at)) begin
               fan_in = nz;
            end else begin
               fan_in = fan_ff && nz;
            end
         end
         if (req_last) begin
            off_in   = '0;
            done_in  = 1'b0;
            fan_in   = 1'b1;
            value_in = '0;
         end
      end
   end

   // burst bookkeeping
   always_comb begin
      bk_in    = bk_ff;
      blank_in = blank_ff;
      byte_in  = byte_ff;
      idx_in   = idx_ff;
      if (cmd.take_byte && start_burst) begin
         blank_in = blank;
         byte_in  = req_data;
         idx_in   = '0;
         if (flush_desc) begin
            bk_in = (record_kind == prd_pkg::KIND_OUT) ? prd_pkg::BK_OUT_DESC
                                                       : prd_pkg::BK_IN_DESC;
         end else begin
            bk_in = (record_kind == prd_pkg::KIND_OUT) ? prd_pkg::BK_OUT_LABEL
                                                       : prd_pkg::BK_IN_LABEL;
         end
      end else if (cmd.load_item) begin
         idx_in = idx_ff + POS_W'(1);
      end
   end

   always_comb begin
      burst_item = '0;
      lbl_char   = prd_pkg::fold_char(blank_ff ? '0 : label_rd_ff);
      last_item  = 1'b0;
      case (bk_ff)
         prd_pkg::BK_IN_DESC: begin
            burst_item.field_id    = prd_pkg::FID_IN_DESC;
            burst_item.byte_pos    = idx_ff;
            burst_item.field_value = {{(VALUE_W-DATA_W){1'b0}},
                                      (blank_ff ? '0 : text_rd_ff)};
            last_item = idx_ff == POS_W'(IN_DESC_LAST);
         end
         prd_pkg::BK_OUT_DESC: begin
            if (HAS_LOW_ITEM && (idx_ff == POS_W'(OUT_DESC_LEN))) begin
               burst_item.field_id    = prd_pkg::FID_OUT_LOW;
               burst_item.field_value = prd_pkg::volt_clamp(byte_ff);
            end else begin
               burst_item.field_id    = prd_pkg::FID_OUT_DESC;
               burst_item.byte_pos    = idx_ff;
               // text too long: bytes kept, last character cut
               burst_item.field_value =
                  {{(VALUE_W-DATA_W){1'b0}},
                   ((blank_ff && (idx_ff == POS_W'(OUT_DESC_LEN - 1))) ? '0 : text_rd_ff)};
            end
            last_item = idx_ff == POS_W'(OUT_DESC_LAST);
         end
         prd_pkg::BK_IN_LABEL: begin
            burst_item.field_id    = prd_pkg::FID_IN_LABEL;
            burst_item.byte_pos    = idx_ff;
            burst_item.field_value = {{(VALUE_W-DATA_W){1'b0}}, lbl_char};
            last_item = idx_ff == POS_W'(LABEL_LAST);
         end
         default: begin
            burst_item.field_id    = prd_pkg::FID_OUT_LABEL;
            burst_item.byte_pos    = idx_ff;
            burst_item.field_value = {{(VALUE_W-DATA_W){1'b0}}, lbl_char};
            last_item = idx_ff == POS_W'(LABEL_LAST);
         end
      endcase
   end

   // output register
   always_comb begin
      out_free     = !out_valid_ff || rsp_ready;
      out_item_in  = out_item_ff;
      out_valid_in = rsp_ready ? 1'b0 : out_valid_ff;
      if (cmd.take_byte && sgl_valid) begin
         out_item_in  = sgl;
         out_valid_in = 1'b1;
      end else if (cmd.load_item) begin
         out_item_in  = burst_item;
         out_valid_in = 1'b1;
      end
   end

   assign status.start_burst = start_burst;
   assign status.last_item   = last_item;
   assign status.out_free    = out_free;
   assign rsp_valid          = out_valid_ff;
   assign rsp_item           = out_item_ff;

   always_ff @(posedge clock) begin
      if (cmd.take_byte && !done_pre) begin
         if (off_ff < OFF_W'(TEXT_DEPTH)) begin
            text_mem[off_ff[TA_W-1:0]] <= req_data;
         end
         if (in_label) begin
            label_mem[lbl_rel[LA_W-1:0]] <= req_data;
         end
      end
      if (cmd.issue_read) begin
         if (int'(idx_ff) < TEXT_DEPTH) begin
            text_rd_ff <= text_mem[idx_ff[TA_W-1:0]];
         end
         if (int'(idx_ff) < LABEL_LEN) begin
            label_rd_ff <= label_mem[idx_ff[LA_W-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff       <= '0;
         done_ff      <= 1'b0;
         fan_ff       <= 1'b1;
         value_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         off_ff       <= off_in;
         done_ff      <= done_in;
         fan_ff       <= fan_in;
         value_ff     <= value_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bk_ff       <= bk_in;
      blank_ff    <= blank_in;
      byte_ff     <= byte_in;
      idx_ff      <= idx_in;
      out_item_ff <= out_item_in;
   end

endmodule

`default_nettype wire

FILE: src/point_record_decoder_core.sv
`default_nettype none

// channel   dir   handshake              payload
// req       in    req_tvalid/req_tready  tdata[7:0] data_byte, tlast end_of_buffer
// rsp       out   rsp_tvalid/rsp_tready  tdata field_id/byte_pos/field_value,
//                                        tlast record_end, tuser status
// csr       in    psel/penable/pready    word 0 record_kind
//
// a byte that gives at most one item is taken straight into the output register
// a byte that closes a text field gives its characters one item at a time, each
// through a read of the single-port text or label memory and then the output register
// no input is taken while such a burst drains (up to 21 items)
// synchronous reset clears control state and record_kind; text memories keep
// their contents; a low rsp_tready holds the output item and stops input

module point_record_decoder_core #(
   parameter int IN_DESC_LEN  = 21,
   parameter int LABEL_LEN    = 9,
   parameter int OUT_DESC_LEN = 19
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [7:0]                         req_tdata,   // [7:0] data_byte
   input  wire                                req_tlast,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // [3:0] field_id, [8:4] byte_pos, [40:9] field_value, [47:41] zero
   output logic [prd_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tuser,   // [0] status
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [prd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [prd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [prd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic                   record_kind_ff, record_kind_in;
   prd_pkg::ctrl_cmd_type  cmd;
   prd_pkg::dp_status_type st;
   prd_pkg::result_type    item;

   assign csr_pready = 1'b1;

   always_comb begin
      record_kind_in = record_kind_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          (csr_paddr[2] == prd_pkg::REG_RECORD_KIND)) begin
         record_kind_in = csr_pwdata[0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == prd_pkg::REG_RECORD_KIND) begin
         csr_prdata = {{(prd_pkg::CSR_DATA_W-1){1'b0}}, record_kind_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         record_kind_ff <= prd_pkg::KIND_IN;
      end else begin
         record_kind_ff <= record_kind_in;
      end
   end

   prd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (st),
      .cmd        (cmd)
   );

   prd_dpath #(
      .IN_DESC_LEN  (IN_DESC_LEN),
      .LABEL_LEN    (LABEL_LEN),
      .OUT_DESC_LEN (OUT_DESC_LEN)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .record_kind (record_kind_ff),
      .req_data    (req_tdata),
      .req_last    (req_tlast),
      .cmd         (cmd),
      .status      (st),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_item    (item)
   );

   assign rsp_tdata = {{(prd_pkg::RSP_TDATA_W - prd_pkg::FID_W - prd_pkg::POS_W
                         - prd_pkg::VALUE_W){1'b0}},
                       item.field_value, item.byte_pos, item.field_id};
   assign rsp_tlast = item.record_end;
   assign rsp_tuser = item.status;

   // an end-of-buffer byte never leaves a burst behind it
   a_eob_closes: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> (!rsp_tvalid || rsp_tlast))
      else $error("item after end of buffer is not a record end");

   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && (rsp_tdata == '0)))
      else $error("short-record item malformed");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |-> st.out_free)
      else $error("burst item loaded over a pending item");

   a_no_take_in_burst: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |-> !req_tready)
      else $error("input taken while a burst drains");

endmodule

`default_nettype wire
